FILE: rtl/kfd_pkg.sv
// Shared types and constants for the KISS frame decoder with checksum.
`timescale 1ns / 1ps

package kfd_pkg;

    // Framing bytes
    localparam logic [7:0] FEND_BYTE  = 8'hC0;
    localparam logic [7:0] FESC_BYTE  = 8'hDB;
    localparam logic [7:0] TFEND_BYTE = 8'hDC;
    localparam logic [7:0] TFESC_BYTE = 8'hDD;

    localparam int MAX_PAYLOAD = 4096;
    localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1);

    // Result queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        PH_WAIT   = 3'd0,
        PH_HEADER = 3'd1,
        PH_BODY   = 3'd2,
        PH_DONE   = 3'd3,
        PH_BAD    = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BAD      = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_CSUM     = 3'd3,
        ST_OVERFLOW = 3'd4
    } status_t;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_STATUS  = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t            kind;
        logic [7:0]       payload_byte;
        logic [3:0]       port;
        logic [3:0]       command;
        logic [LEN_W-1:0] payload_length;
        status_t          status;
        logic             last;
    } result_t;

    // Results raised by one accepted byte: a payload byte, a status, or both
    typedef struct packed {
        logic    pay_valid;
        result_t pay;
        logic    stat_valid;
        result_t stat;
    } result_pair_t;

endpackage

FILE: rtl/kfd_deframe.sv
// Per-byte deframing state machine: unescape, count, sum and status.
`timescale 1ns / 1ps

module kfd_deframe (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 byte_fire,
    input  logic [7:0]           rx_byte,
    input  logic                 buffer_last,
    input  logic                 check_enable,
    output kfd_pkg::result_pair_t results
);

    localparam logic [kfd_pkg::LEN_W-1:0] MAX_COUNT =
        kfd_pkg::LEN_W'(kfd_pkg::MAX_PAYLOAD);

    kfd_pkg::phase_t            phase_reg,    phase_next;
    logic                       esc_reg,      esc_next;
    logic [1:0]                 seen_reg,     seen_next;
    logic [kfd_pkg::LEN_W-1:0]  count_reg,    count_next;
    logic [7:0]                 sum_reg,      sum_next;
    logic [7:0]                 prev_reg,     prev_next;
    logic [3:0]                 port_reg,     port_next;
    logic [3:0]                 cmd_reg,      cmd_next;
    logic                       ovf_reg,      ovf_next;

    logic [7:0]                 decoded;
    logic [kfd_pkg::LEN_W-1:0]  net_len;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= kfd_pkg::PH_WAIT;
            esc_reg   <= 1'b0;
            seen_reg  <= 2'd0;
            count_reg <= '0;
            sum_reg   <= 8'd0;
            prev_reg  <= 8'd0;
            port_reg  <= 4'd0;
            cmd_reg   <= 4'd0;
            ovf_reg   <= 1'b0;
        end
        else if (byte_fire)
        begin
            phase_reg <= phase_next;
            esc_reg   <= esc_next;
            seen_reg  <= seen_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
            prev_reg  <= prev_next;
            port_reg  <= port_next;
            cmd_reg   <= cmd_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        esc_next   = esc_reg;
        seen_next  = (seen_reg == 2'd3) ? 2'd3 : seen_reg + 2'd1;
        count_next = count_reg;
        sum_next   = sum_reg;
        prev_next  = prev_reg;
        port_next  = port_reg;
        cmd_next   = cmd_reg;
        ovf_next   = ovf_reg;
        decoded    = rx_byte;
        net_len    = '0;
        results    = '0;

        unique case (phase_reg)
            kfd_pkg::PH_WAIT:
            begin
                phase_next = (rx_byte == kfd_pkg::FEND_BYTE) ? kfd_pkg::PH_HEADER
                                                             : kfd_pkg::PH_BAD;
            end
            kfd_pkg::PH_HEADER:
            begin
                port_next  = rx_byte[7:4];
                cmd_next   = rx_byte[3:0];
                phase_next = kfd_pkg::PH_BODY;
            end
            kfd_pkg::PH_BODY:
            begin
                if (rx_byte == kfd_pkg::FEND_BYTE)
                begin
                    phase_next = kfd_pkg::PH_DONE;
                end
                else if (rx_byte == kfd_pkg::FESC_BYTE)
                begin
                    esc_next = 1'b1;
                end
                else
                begin
                    if (esc_reg && rx_byte == kfd_pkg::TFESC_BYTE)
                        decoded = kfd_pkg::FESC_BYTE;
                    else if (esc_reg && rx_byte == kfd_pkg::TFEND_BYTE)
                        decoded = kfd_pkg::FEND_BYTE;
                    esc_next = 1'b0;
                    if (count_reg >= MAX_COUNT)
                    begin
                        // drop bytes past the bound
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        if (count_reg != '0)
                            sum_next = sum_reg + prev_reg;
                        prev_next  = decoded;
                        count_next = count_reg + 1'b1;
                        results.pay_valid            = 1'b1;
                        results.pay.kind             = kfd_pkg::KIND_PAYLOAD;
                        results.pay.payload_byte     = decoded;
                        results.pay.port             = port_reg;
                        results.pay.command          = cmd_reg;
                        results.pay.status           = kfd_pkg::ST_OK;
                    end
                end
            end
            kfd_pkg::PH_DONE,
            kfd_pkg::PH_BAD:
            begin
            end
            default:
            begin
            end
        endcase

        if (buffer_last)
        begin
            net_len = count_next -
                      kfd_pkg::LEN_W'(check_enable && (count_next != '0));
            results.stat_valid   = 1'b1;
            results.stat.kind    = kfd_pkg::KIND_STATUS;
            results.stat.last    = 1'b1;
            results.stat.port    = port_next;
            results.stat.command = cmd_next;
            if (phase_next == kfd_pkg::PH_BAD || seen_next != 2'd3)
            begin
                results.stat.status  = kfd_pkg::ST_BAD;
                results.stat.port    = 4'd0;
                results.stat.command = 4'd0;
            end
            else if (count_next == '0)
            begin
                results.stat.status = kfd_pkg::ST_EMPTY;
            end
            else if (ovf_next)
            begin
                results.stat.status         = kfd_pkg::ST_OVERFLOW;
                results.stat.payload_length = net_len;
            end
            else if (check_enable && ~sum_next != prev_next)
            begin
                results.stat.status = kfd_pkg::ST_CSUM;
            end
            else
            begin
                results.stat.status         = kfd_pkg::ST_OK;
                results.stat.payload_length = net_len;
            end

            // clear per-buffer state
            phase_next = kfd_pkg::PH_WAIT;
            esc_next   = 1'b0;
            seen_next  = 2'd0;
            count_next = '0;
            sum_next   = 8'd0;
            prev_next  = 8'd0;
            port_next  = 4'd0;
            cmd_next   = 4'd0;
            ovf_next   = 1'b0;
        end
    end

endmodule

FILE: rtl/kfd_result_queue.sv
// Small result queue: takes up to two results a cycle, delivers one.
`timescale 1ns / 1ps

module kfd_result_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  kfd_pkg::result_pair_t pair,
    output logic                  room,
    output logic                  out_valid,
    input  logic                  out_ready,
    output kfd_pkg::result_t      head
);

    kfd_pkg::result_t           entry_reg [kfd_pkg::QUEUE_DEPTH];
    logic [kfd_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [kfd_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [kfd_pkg::QCNT_W-1:0] count_reg,  count_next;

    logic                       wr0, wr1, pop;
    kfd_pkg::result_t           first;
    logic [kfd_pkg::QPTR_W-1:0] wr_ptr_plus1;
    logic [kfd_pkg::QCNT_W-1:0] n_push;

    assign room      = count_reg <= kfd_pkg::QCNT_W'(kfd_pkg::QUEUE_DEPTH - 2);
    assign out_valid = count_reg != '0;
    assign head      = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    assign wr0          = push && (pair.pay_valid || pair.stat_valid);
    assign wr1          = push && pair.pay_valid && pair.stat_valid;
    assign first        = pair.pay_valid ? pair.pay : pair.stat;
    assign wr_ptr_plus1 = wr_ptr_reg + 1'b1;
    assign n_push       = kfd_pkg::QCNT_W'(wr0) + kfd_pkg::QCNT_W'(wr1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + kfd_pkg::QPTR_W'(n_push);
        rd_ptr_next = rd_ptr_reg + kfd_pkg::QPTR_W'(pop);
        count_next  = count_reg + n_push - kfd_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr0)
            entry_reg[wr_ptr_reg] <= first;
        if (wr1)
            entry_reg[wr_ptr_plus1] <= pair.stat;
    end

endmodule

FILE: rtl/kiss_frame_decoder_checksum.sv
// Top level of the KISS frame decoder with inverted-sum checksum.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid/in_ready): one raw byte of a received buffer per
//   item, with buffer_last high on the buffer's final byte. The decoder
//   strips the opening FEND, latches port and command from the header byte,
//   unescapes the body and stops at the closing FEND.
//   Output channel (out_valid/out_ready): one result per item. kind 0 carries
//   a decoded payload byte; kind 1 with last high is the status that closes
//   the buffer (ok, bad/short, empty, checksum fail, overflow).
//   Configuration: cfg_wr_en/cfg_wr_data write check_enable;
//   write it only between buffers.
// Timing
//   A result enters the result queue when its byte is accepted and shows on
//   the output once the results ahead of it are taken. One byte per cycle is
//   sustained while the receiver keeps up; a byte that yields both a payload
//   result and the status pushes two results, which the four-entry result
//   queue absorbs. in_ready drops only when that queue cannot take two more
//   results, so a stalled receiver backs up into the input and none is lost.
// Reset
//   rst_n clears the frame state, empties the queue and sets check_enable.

module kiss_frame_decoder_checksum (
    input  logic                        clk,
    input  logic                        rst_n,
    // configuration
    input  logic                        cfg_wr_en,
    input  logic                        cfg_wr_data,
    // byte input
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [7:0]                  rx_byte,
    input  logic                        buffer_last,
    // result output
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        kind,
    output logic [7:0]                  payload_byte,
    output logic [3:0]                  port,
    output logic [3:0]                  command,
    output logic [kfd_pkg::LEN_W-1:0]   payload_length,
    output logic [2:0]                  status,
    output logic                        last
);

    logic                  check_enable_reg;
    logic                  byte_fire;
    logic                  room;
    kfd_pkg::result_pair_t pair;
    kfd_pkg::result_t      head;

    // Hold the checksum enable; default on after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            check_enable_reg <= 1'b1;
        else if (cfg_wr_en)
            check_enable_reg <= cfg_wr_data;
    end

    assign in_ready  = room;
    assign byte_fire = in_valid && in_ready;

    // Advance the frame state by one byte and form its results
    kfd_deframe u_deframe (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_fire    (byte_fire),
        .rx_byte      (rx_byte),
        .buffer_last  (buffer_last),
        .check_enable (check_enable_reg),
        .results      (pair)
    );

    // Queue results so the input keeps flowing while the receiver stalls
    kfd_result_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (byte_fire),
        .pair      (pair),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign kind           = head.kind;
    assign payload_byte   = head.payload_byte;
    assign port           = head.port;
    assign command        = head.command;
    assign payload_length = head.payload_length;
    assign status         = head.status;
    assign last           = head.last;

endmodule

FILE: bench/kiss_frame_decoder_checksum_test.sv
// Self-checking bench for the KISS frame decoder: random buffers, random stalls, checksum modes.
`timescale 1ns / 1ps

module kiss_frame_decoder_checksum_test;

    // Cycles with no handshake on either side before the run is declared hung.
    // The longest legal quiet stretch is the long receiver hold plus a gap.
    localparam int WATCHDOG_LIMIT = 3000;
    // Receiver hold-off that backs the decoder up into its input.
    localparam int LONG_HOLD      = 300;
    localparam int HOLD_AFTER     = 120;
    // Settle time after every result is in, with a little slack.
    localparam int DRAIN_CYCLES   = 6;
    localparam int PHASE_BYTES    = 75;

    typedef struct {
        logic [7:0] data;
        logic       closes;
    } raw_item_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_wr_en = 1'b0;
    logic                      cfg_wr_data = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic [7:0]                rx_byte = 8'h00;
    logic                      buffer_last = 1'b0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic                      kind;
    logic [7:0]                payload_byte;
    logic [3:0]                port;
    logic [3:0]                command;
    logic [kfd_pkg::LEN_W-1:0] payload_length;
    logic [2:0]                status;
    logic                      last;

    kiss_frame_decoder_checksum uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .rx_byte        (rx_byte),
        .buffer_last    (buffer_last),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .payload_byte   (payload_byte),
        .port           (port),
        .command        (command),
        .payload_length (payload_length),
        .status         (status),
        .last           (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Bytes waiting to be offered, and the results the decoder still owes.
    raw_item_t         raw_items[$];
    kfd_pkg::result_t  expected_results[$];
    logic [7:0]        frame_bytes[$];

    int queued_total   = 0;
    int accepted_total = 0;
    int results_seen   = 0;
    int error_count    = 0;
    int stall_cycles   = 0;

    // Sender and receiver pacing
    int send_gap    = 0;
    bit send_calm   = 1'b0;
    int recv_wait   = 0;
    bit recv_calm   = 1'b0;
    int hold_left   = 0;
    bit hold_done   = 1'b0;

    // Shadow of the decoder: configuration plus per-buffer frame state.
    logic                      sh_check = 1'b1;
    kfd_pkg::phase_t           sh_phase = kfd_pkg::PH_WAIT;
    logic                      sh_escape = 1'b0;
    logic [1:0]                sh_seen = 2'd0;
    logic [kfd_pkg::LEN_W-1:0] sh_count = '0;
    logic [7:0]                sh_sum = 8'h00;
    logic [7:0]                sh_prev = 8'h00;
    logic [3:0]                sh_port = 4'h0;
    logic [3:0]                sh_cmd = 4'h0;
    logic                      sh_over = 1'b0;

    task automatic note_mismatch(input string what, input int got, input int want);
        $display("result %0d: %s got %0d want %0d", results_seen, what, got, want);
        error_count++;
    endtask

    // Advance the shadow decoder by one accepted byte and queue what it must emit.
    task automatic deframe_byte(input logic [7:0] b, input logic closes);
        kfd_pkg::result_t          r;
        logic [7:0]                d;
        logic [kfd_pkg::LEN_W-1:0] net;
        if (sh_seen < 2'd3)
            sh_seen++;
        case (sh_phase)
            kfd_pkg::PH_WAIT:
                sh_phase = (b == kfd_pkg::FEND_BYTE) ? kfd_pkg::PH_HEADER
                                                     : kfd_pkg::PH_BAD;
            kfd_pkg::PH_HEADER:
            begin
                // Any byte, FEND included, is taken as the header here.
                sh_port  = b[7:4];
                sh_cmd   = b[3:0];
                sh_phase = kfd_pkg::PH_BODY;
            end
            kfd_pkg::PH_BODY:
            begin
                if (b == kfd_pkg::FEND_BYTE)
                    sh_phase = kfd_pkg::PH_DONE;
                else if (b == kfd_pkg::FESC_BYTE)
                    sh_escape = 1'b1;
                else
                begin
                    d = b;
                    if (sh_escape && b == kfd_pkg::TFESC_BYTE)
                        d = kfd_pkg::FESC_BYTE;
                    else if (sh_escape && b == kfd_pkg::TFEND_BYTE)
                        d = kfd_pkg::FEND_BYTE;
                    sh_escape = 1'b0;
                    if (sh_count >= kfd_pkg::MAX_PAYLOAD)
                        sh_over = 1'b1;
                    else
                    begin
                        // The sum trails by one byte so the newest can serve as checksum.
                        if (sh_count != 0)
                            sh_sum = sh_sum + sh_prev;
                        sh_prev  = d;
                        sh_count = sh_count + 1'b1;
                        r = '0;
                        r.kind         = kfd_pkg::KIND_PAYLOAD;
                        r.payload_byte = d;
                        r.port         = sh_port;
                        r.command      = sh_cmd;
                        r.status       = kfd_pkg::ST_OK;
                        expected_results.push_back(r);
                    end
                end
            end
            default:
                ;
        endcase

        if (closes)
        begin
            net = sh_count;
            if (sh_check && sh_count != 0)
                net = net - 1'b1;
            r = '0;
            r.kind    = kfd_pkg::KIND_STATUS;
            r.last    = 1'b1;
            r.port    = sh_port;
            r.command = sh_cmd;
            // Priority: bad or short, empty, overflow, checksum.
            if (sh_phase == kfd_pkg::PH_BAD || sh_seen < 2'd3)
            begin
                r.status  = kfd_pkg::ST_BAD;
                r.port    = 4'h0;
                r.command = 4'h0;
            end
            else if (sh_count == 0)
                r.status = kfd_pkg::ST_EMPTY;
            else if (sh_over)
            begin
                r.status         = kfd_pkg::ST_OVERFLOW;
                r.payload_length = net;
            end
            else if (sh_check && (~sh_sum) != sh_prev)
                r.status = kfd_pkg::ST_CSUM;
            else
            begin
                r.status         = kfd_pkg::ST_OK;
                r.payload_length = net;
            end
            expected_results.push_back(r);

            sh_phase  = kfd_pkg::PH_WAIT;
            sh_escape = 1'b0;
            sh_seen   = 2'd0;
            sh_count  = '0;
            sh_sum    = 8'h00;
            sh_prev   = 8'h00;
            sh_port   = 4'h0;
            sh_cmd    = 4'h0;
            sh_over   = 1'b0;
        end
    endtask

    // Sender: offer queued bytes, hold each until taken, then wait a drawn gap.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                deframe_byte(rx_byte, buffer_last);
                accepted_total++;
                if ($urandom_range(0, 39) == 0)
                    send_calm = ~send_calm;
                // Keep pushing while the receiver is held so the decoder fills.
                send_gap = (send_calm || hold_left > 0) ? 0 : $urandom_range(0, 17);
                if (send_gap == 0 && raw_items.size() != 0)
                begin
                    rx_byte     <= raw_items[0].data;
                    buffer_last <= raw_items[0].closes;
                    void'(raw_items.pop_front());
                end
                else
                    in_valid <= 1'b0;
            end
            else if (!in_valid)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (raw_items.size() != 0)
                begin
                    in_valid    <= 1'b1;
                    rx_byte     <= raw_items[0].data;
                    buffer_last <= raw_items[0].closes;
                    void'(raw_items.pop_front());
                end
            end
        end
    end

    // Receiver: check each taken result against the oldest expectation, then stall.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                    note_mismatch("unexpected result, kind", kind, -1);
                else
                begin
                    if (kind !== expected_results[0].kind)
                        note_mismatch("kind", kind, expected_results[0].kind);
                    if (payload_byte !== expected_results[0].payload_byte)
                        note_mismatch("payload_byte", payload_byte,
                                      expected_results[0].payload_byte);
                    if (port !== expected_results[0].port)
                        note_mismatch("port", port, expected_results[0].port);
                    if (command !== expected_results[0].command)
                        note_mismatch("command", command, expected_results[0].command);
                    if (payload_length !== expected_results[0].payload_length)
                        note_mismatch("payload_length", payload_length,
                                      expected_results[0].payload_length);
                    if (status !== expected_results[0].status)
                        note_mismatch("status", status, expected_results[0].status);
                    if (last !== expected_results[0].last)
                        note_mismatch("last", last, expected_results[0].last);
                    void'(expected_results.pop_front());
                end
                results_seen++;
                if ($urandom_range(0, 31) == 0)
                    recv_calm = ~recv_calm;
                recv_wait = recv_calm ? 0 : $urandom_range(0, 17);
                // Once, hold off long enough that the result queue backs up.
                if (!hold_done && results_seen >= HOLD_AFTER)
                begin
                    hold_left = LONG_HOLD;
                    hold_done = 1'b1;
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (recv_wait > 0)
            begin
                recv_wait--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Hang detection: count cycles with no handshake on either channel.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("kiss_frame_decoder_checksum_test: errors");
                $finish;
            end
        end
    end

    // Move the staged buffer to the sender, marking its final byte.
    task automatic flush_buffer();
        raw_item_t it;
        while (frame_bytes.size() != 0)
        begin
            it.data   = frame_bytes.pop_front();
            it.closes = (frame_bytes.size() == 0);
            raw_items.push_back(it);
            queued_total++;
        end
    endtask

    // Bias toward the framing bytes and the byte extremes.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 11))
            0:       return kfd_pkg::FEND_BYTE;
            1:       return kfd_pkg::FESC_BYTE;
            2:       return kfd_pkg::TFEND_BYTE;
            3:       return kfd_pkg::TFESC_BYTE;
            4:       return 8'h00;
            5:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Escape one payload byte; now and then put a stray escape before a plain byte.
    task automatic stage_data(input logic [7:0] d);
        if (d == kfd_pkg::FEND_BYTE)
        begin
            frame_bytes.push_back(kfd_pkg::FESC_BYTE);
            frame_bytes.push_back(kfd_pkg::TFEND_BYTE);
        end
        else if (d == kfd_pkg::FESC_BYTE)
        begin
            frame_bytes.push_back(kfd_pkg::FESC_BYTE);
            frame_bytes.push_back(kfd_pkg::TFESC_BYTE);
        end
        else
        begin
            if ($urandom_range(0, 15) == 0)
                frame_bytes.push_back(kfd_pkg::FESC_BYTE);
            frame_bytes.push_back(d);
        end
    endtask

    // Stage and send one frame: FEND, header, payload, optional checksum, close, junk.
    task automatic send_frame(input logic [7:0] header, input int n, input bit with_sum,
                              input bit sum_good, input bit closed, input int junk);
        logic [7:0] d;
        logic [7:0] total;
        total = 8'h00;
        frame_bytes.push_back(kfd_pkg::FEND_BYTE);
        frame_bytes.push_back(header);
        for (int i = 0; i < n; i++)
        begin
            d = pick_byte();
            total = total + d;
            stage_data(d);
        end
        if (with_sum)
            stage_data(sum_good ? ~total : (~total ^ 8'($urandom_range(1, 255))));
        if (closed)
        begin
            frame_bytes.push_back(kfd_pkg::FEND_BYTE);
            // Bytes after the closing FEND must be ignored.
            for (int i = 0; i < junk; i++)
                frame_bytes.push_back(pick_byte());
        end
        flush_buffer();
    endtask

    // Broken buffer: short, random bytes, often a plausible start.
    task automatic send_noise();
        int n;
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++)
            frame_bytes.push_back((i == 0 && $urandom_range(0, 4) < 3) ? kfd_pkg::FEND_BYTE
                                                                       : pick_byte());
        flush_buffer();
    endtask

    // Hold until every byte is taken and every result is in, then let the pipe settle.
    task automatic wait_idle();
        do
            @(posedge clk);
        while (accepted_total != queued_total || expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_check(input logic v);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sh_check = v;
    endtask

    initial
    begin
        int n;
        int phase_start;
        bit closed;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed buffers, checking on.
        write_check(1'b1);
        // Short: FEND alone, then FEND plus header.
        frame_bytes = '{kfd_pkg::FEND_BYTE};
        flush_buffer();
        frame_bytes = '{kfd_pkg::FEND_BYTE, 8'h00};
        flush_buffer();
        // Bad start, even though a frame follows.
        frame_bytes = '{8'h00, kfd_pkg::FEND_BYTE, 8'hFF};
        flush_buffer();
        // FEND as header, one payload byte 0xFF that matches an empty sum.
        frame_bytes = '{kfd_pkg::FEND_BYTE, kfd_pkg::FEND_BYTE, 8'hFF};
        flush_buffer();
        // Empty frame with all-ones header.
        frame_bytes = '{kfd_pkg::FEND_BYTE, 8'hFF, kfd_pkg::FEND_BYTE};
        flush_buffer();
        // Both escapes, escape after escape, escape before a plain byte,
        // FEND while an escape is pending, then junk.
        frame_bytes = '{kfd_pkg::FEND_BYTE, 8'h5A,
                        kfd_pkg::FESC_BYTE, kfd_pkg::TFEND_BYTE,
                        kfd_pkg::FESC_BYTE, kfd_pkg::TFESC_BYTE,
                        kfd_pkg::FESC_BYTE, kfd_pkg::FESC_BYTE, kfd_pkg::TFESC_BYTE,
                        kfd_pkg::FESC_BYTE, 8'h41,
                        kfd_pkg::FESC_BYTE, kfd_pkg::FEND_BYTE, 8'h77};
        flush_buffer();
        // Good checksum frame.
        send_frame(8'h00, 3, 1'b1, 1'b1, 1'b1, 0);
        wait_idle();

        // Checking off: single byte, frame left open at buffer end.
        write_check(1'b0);
        frame_bytes = '{kfd_pkg::FEND_BYTE, 8'h21, 8'hAB};
        flush_buffer();
        send_frame(8'h3C, 2, 1'b0, 1'b1, 1'b1, 0);
        wait_idle();

        // Random phases, alternating the check mode.
        for (int ph = 0; ph < 6; ph++)
        begin
            write_check(1'(ph % 2));
            phase_start = queued_total;
            while (queued_total - phase_start < PHASE_BYTES)
            begin
                if ($urandom_range(0, 9) < 7)
                begin
                    n = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 40)
                                                     : $urandom_range(0, 10);
                    closed = ($urandom_range(0, 4) != 0);
                    send_frame(8'($urandom_range(0, 255)), n, sh_check,
                               $urandom_range(0, 7) != 0, closed,
                               closed ? $urandom_range(0, 2) : 0);
                end
                else
                    send_noise();
            end
            wait_idle();
        end

        if (error_count == 0)
            $display("kiss_frame_decoder_checksum_test: clean");
        else
            $display("kiss_frame_decoder_checksum_test: errors");
        $finish;
    end

endmodule

FILE: files.f
rtl/kfd_pkg.sv
rtl/kfd_deframe.sv
rtl/kfd_result_queue.sv
rtl/kiss_frame_decoder_checksum.sv
bench/kiss_frame_decoder_checksum_test.sv
